>>> design/cmr_pkg.sv
package cmr_pkg;

   localparam int MaxPoints = 16;
   localparam int CoordW    = 16;
   localparam int PointW    = 3 * CoordW;
   localparam int IdxW      = $clog2(MaxPoints);
   localparam int CntW      = $clog2(MaxPoints + 1);
   localparam int TimeW     = 24;
   localparam int ClkW      = 25;
   localparam int PhaseW    = 17;
   localparam int ElapsedW  = 16;
   localparam int OpW       = 3;
   localparam int CsrAddrW  = 4;
   localparam int CsrDataW  = 32;
   localparam int CoefW     = CoordW + 4;
   localparam int ProdW     = CoefW + PhaseW + 1;
   localparam int AccW      = ProdW + 2;

   localparam logic [OpW-1:0] OpAppend = 3'd0;
   localparam logic [OpW-1:0] OpRemove = 3'd1;
   localparam logic [OpW-1:0] OpClear  = 3'd2;
   localparam logic [OpW-1:0] OpReset  = 3'd3;
   localparam logic [OpW-1:0] OpStart  = 3'd4;
   localparam logic [OpW-1:0] OpTick   = 3'd5;

   localparam logic [1:0] RegTotalTime = 2'd0;
   localparam logic [1:0] RegLoopMode  = 2'd1;
   localparam logic [1:0] RegCycleMode = 2'd2;

   typedef struct packed {
      logic signed [CoordW-1:0] x;
      logic signed [CoordW-1:0] y;
      logic signed [CoordW-1:0] z;
   } point_type;

   typedef struct packed {
      logic [OpW-1:0]           opcode;
      logic signed [CoordW-1:0] point_x;
      logic signed [CoordW-1:0] point_y;
      logic signed [CoordW-1:0] point_z;
      logic [ElapsedW-1:0]      elapsed;
   } req_type;

   typedef struct packed {
      logic signed [CoordW-1:0] pos_x;
      logic signed [CoordW-1:0] pos_y;
      logic signed [CoordW-1:0] pos_z;
      logic [IdxW-1:0]          segment_index;
      logic [PhaseW-1:0]        phase;
      logic                     status;
      logic                     is_running;
   } rsp_type;

   function automatic logic signed [CoordW-1:0] coord_of(input point_type p,
                                                         input logic [1:0] axis);
      logic signed [CoordW-1:0] v;
      case (axis)
         2'd0: v = p.x;
         2'd1: v = p.y;
         default: v = p.z;
      endcase
      return v;
   endfunction

endpackage

>>> design/cmr_ram.sv
module cmr_ram #(
   parameter int Width = 48,
   parameter int Depth = 16,
   localparam int AddrW = $clog2(Depth)
) (
   input  logic             clock,
   input  logic             we,
   input  logic [AddrW-1:0] waddr,
   input  logic [Width-1:0] wdata,
   input  logic [AddrW-1:0] raddr,
   output logic [Width-1:0] rdata
);

   logic [Width-1:0] mem_ff [Depth];
   logic [Width-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
      rdata_ff <= mem_ff[raddr];
   end

   assign rdata = rdata_ff;

endmodule

>>> design/catmull_rom_path_follower.sv
// Catmull-Rom path follower: keeps up to 16 waypoints in a small synchronous RAM and, on each
// tick while running, returns a uniform Catmull-Rom position between the current and next
// waypoint. One item is worked at a time; a new item is taken once the previous result sits in
// the output register. Append, remove, clear and a tick while stopped go straight to the output
// register, reset with points stored adds a read-back of the first waypoint, start runs 24 steps
// of the bit-serial divider for the segment length, and a tick while running takes the item,
// advances, checks the phase, runs 16 divider steps for the phase, reads four waypoints through
// the single RAM read port, forms t^2 and t^3, builds the cubic for x, y and z in turn on one
// shared multiplier and loads the output register. A tick whose phase saturates at one skips the
// divider. A stalled result holds the block for as long as it waits.
module catmull_rom_path_follower (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_valid,
   output logic                             req_stall,
   input  cmr_pkg::req_type                 req_data,
   output logic                             rsp_valid,
   input  logic                             rsp_stall,
   output cmr_pkg::rsp_type                 rsp_data,
   input  logic                             csr_psel,
   input  logic                             csr_penable,
   input  logic                             csr_pwrite,
   input  logic [cmr_pkg::CsrAddrW-1:0]     csr_paddr,
   input  logic [cmr_pkg::CsrDataW-1:0]     csr_pwdata,
   output logic [cmr_pkg::CsrDataW-1:0]     csr_prdata,
   output logic                             csr_pready
);

   typedef enum logic [10:0] {
      ST_IDLE  = 11'b00000000001,
      ST_RSTWB = 11'b00000000010,
      ST_DIV   = 11'b00000000100,
      ST_ADV   = 11'b00000001000,
      ST_PH    = 11'b00000010000,
      ST_RD    = 11'b00000100000,
      ST_T2    = 11'b00001000000,
      ST_T3    = 11'b00010000000,
      ST_MAC   = 11'b00100000000,
      ST_SAT   = 11'b01000000000,
      ST_FIN   = 11'b10000000000
   } state_type;

   state_type                          state_ff, state_in;
   logic [cmr_pkg::TimeW-1:0]          total_time_ff, total_time_in;
   logic                               loop_mode_ff, loop_mode_in;
   logic                               cycle_mode_ff, cycle_mode_in;
   logic [cmr_pkg::CntW-1:0]           count_ff, count_in;
   logic [cmr_pkg::IdxW-1:0]           cur_ff, cur_in;
   logic [cmr_pkg::IdxW-1:0]           nxt_ff, nxt_in;
   logic [cmr_pkg::ClkW-1:0]           clk_ff, clk_in;
   logic [cmr_pkg::TimeW-1:0]          len_ff, len_in;
   logic                               run_ff, run_in;
   cmr_pkg::point_type                 pos_ff, pos_in;
   logic [cmr_pkg::PhaseW-1:0]         phase_ff, phase_in;
   logic                               status_ff, status_in;
   logic                               tick_ff, tick_in;
   logic [cmr_pkg::TimeW-1:0]          rem_ff, rem_in;
   logic [cmr_pkg::TimeW-1:0]          quo_ff, quo_in;
   logic [cmr_pkg::TimeW-1:0]          den_ff, den_in;
   logic [4:0]                         step_ff, step_in;
   logic [2:0]                         rd_ff, rd_in;
   cmr_pkg::point_type                 pts_ff [4];
   cmr_pkg::point_type                 pts_in [4];
   logic [cmr_pkg::PhaseW-1:0]         t2_ff, t2_in;
   logic [cmr_pkg::PhaseW-1:0]         t3_ff, t3_in;
   logic signed [cmr_pkg::ProdW-1:0]   prod_ff, prod_in;
   logic signed [cmr_pkg::AccW-1:0]    acc_ff, acc_in;
   logic [1:0]                         axis_ff, axis_in;
   logic [1:0]                         term_ff, term_in;
   logic                               rsp_valid_ff, rsp_valid_in;
   cmr_pkg::rsp_type                   rsp_data_ff, rsp_data_in;

   logic                               ram_we;
   logic [cmr_pkg::IdxW-1:0]           ram_waddr;
   logic [cmr_pkg::PointW-1:0]         ram_wdata;
   logic [cmr_pkg::IdxW-1:0]           ram_raddr;
   logic [cmr_pkg::PointW-1:0]         ram_rdata;

   logic                               csr_write;
   logic [cmr_pkg::ClkW:0]             clk_sum;
   logic [cmr_pkg::CntW-1:0]           segs;
   logic [cmr_pkg::TimeW:0]            rem_sh;
   logic                               div_ge;
   logic [cmr_pkg::TimeW-1:0]          rem_new;
   logic [cmr_pkg::TimeW-1:0]          quo_new;
   logic [4:0]                         div_last;
   logic [cmr_pkg::IdxW-1:0]           idx [4];
   logic                               two_pts;
   logic [2*cmr_pkg::PhaseW-1:0]       sq;
   logic [2*cmr_pkg::PhaseW-1:0]       cu;
   logic signed [cmr_pkg::CoefW-1:0]   p0e, p1e, p2e, p3e;
   logic signed [cmr_pkg::CoefW-1:0]   coef_a, coef_b, coef_c, coef_sel;
   logic signed [cmr_pkg::PhaseW:0]    tv_sel;
   logic signed [cmr_pkg::AccW-1:0]    base;
   logic signed [cmr_pkg::AccW-1:0]    acc_sum;
   logic signed [cmr_pkg::AccW-18:0]   q;
   logic signed [cmr_pkg::CoordW-1:0]  q_sat;

   cmr_ram #(.Width(cmr_pkg::PointW), .Depth(cmr_pkg::MaxPoints)) u_store (
      .clock (clock),
      .we    (ram_we),
      .waddr (ram_waddr),
      .wdata (ram_wdata),
      .raddr (ram_raddr),
      .rdata (ram_rdata)
   );

   assign csr_pready = 1'b1;
   assign csr_write  = csr_psel && csr_penable && csr_pwrite;

   always_comb begin
      case (csr_paddr[3:2])
         cmr_pkg::RegTotalTime: csr_prdata = {8'd0, total_time_ff};
         cmr_pkg::RegLoopMode:  csr_prdata = {31'd0, loop_mode_ff};
         cmr_pkg::RegCycleMode: csr_prdata = {31'd0, cycle_mode_ff};
         default: csr_prdata = '0;
      endcase
   end

   assign req_stall = (state_ff != ST_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   assign clk_sum  = {1'b0, clk_ff} + (cmr_pkg::ClkW + 1)'(req_data.elapsed);
   assign segs     = cycle_mode_ff ? count_ff : count_ff - cmr_pkg::CntW'(1);
   assign rem_sh   = {rem_ff, quo_ff[cmr_pkg::TimeW-1]};
   assign div_ge   = rem_sh >= {1'b0, den_ff};
   assign rem_new  = div_ge ? cmr_pkg::TimeW'(rem_sh - {1'b0, den_ff})
                   : rem_sh[cmr_pkg::TimeW-1:0];
   assign quo_new  = {quo_ff[cmr_pkg::TimeW-2:0], div_ge};
   assign div_last = tick_ff ? 5'(cmr_pkg::PhaseW - 2) : 5'(cmr_pkg::TimeW - 1);

   assign two_pts = (count_ff == cmr_pkg::CntW'(2));
   assign idx[1]  = cur_ff;
   assign idx[2]  = nxt_ff;
   assign idx[0]  = two_pts ? cur_ff : ((cur_ff == '0) ? '0 : cur_ff - cmr_pkg::IdxW'(1));
   assign idx[3]  = two_pts ? nxt_ff
                  : ((({1'b0, nxt_ff} + cmr_pkg::CntW'(1)) >= count_ff)
                     ? nxt_ff : nxt_ff + cmr_pkg::IdxW'(1));

   assign sq = phase_ff * phase_ff;
   assign cu = t2_ff * phase_ff;

   assign p0e = cmr_pkg::CoefW'(cmr_pkg::coord_of(pts_ff[0], axis_ff));
   assign p1e = cmr_pkg::CoefW'(cmr_pkg::coord_of(pts_ff[1], axis_ff));
   assign p2e = cmr_pkg::CoefW'(cmr_pkg::coord_of(pts_ff[2], axis_ff));
   assign p3e = cmr_pkg::CoefW'(cmr_pkg::coord_of(pts_ff[3], axis_ff));
   assign coef_a = p2e - p0e;
   assign coef_b = (p0e <<< 1) - ((p1e <<< 2) + p1e) + (p2e <<< 2) - p3e;
   assign coef_c = p3e - p0e + ((p1e <<< 1) + p1e) - ((p2e <<< 1) + p2e);
   assign base   = (cmr_pkg::AccW'(p1e) <<< 17) + cmr_pkg::AccW'(65536);
   assign acc_sum = acc_ff + cmr_pkg::AccW'(prod_ff);

   always_comb begin
      case (term_ff)
         2'd0: begin
            coef_sel = coef_a;
            tv_sel   = $signed({1'b0, phase_ff});
         end
         2'd1: begin
            coef_sel = coef_b;
            tv_sel   = $signed({1'b0, t2_ff});
         end
         default: begin
            coef_sel = coef_c;
            tv_sel   = $signed({1'b0, t3_ff});
         end
      endcase
   end

   assign q     = acc_ff[cmr_pkg::AccW-1:17];
   assign q_sat = (q[cmr_pkg::AccW-18:cmr_pkg::CoordW-1]
                   != {(cmr_pkg::AccW-16-cmr_pkg::CoordW){q[cmr_pkg::CoordW-1]}})
                ? (q[cmr_pkg::AccW-18] ? {1'b1, {(cmr_pkg::CoordW-1){1'b0}}}
                                       : {1'b0, {(cmr_pkg::CoordW-1){1'b1}}})
                : q[cmr_pkg::CoordW-1:0];

   always_comb begin
      state_in      = state_ff;
      total_time_in = total_time_ff;
      loop_mode_in  = loop_mode_ff;
      cycle_mode_in = cycle_mode_ff;
      count_in      = count_ff;
      cur_in        = cur_ff;
      nxt_in        = nxt_ff;
      clk_in        = clk_ff;
      len_in        = len_ff;
      run_in        = run_ff;
      pos_in        = pos_ff;
      phase_in      = phase_ff;
      status_in     = status_ff;
      tick_in       = tick_ff;
      rem_in        = rem_ff;
      quo_in        = quo_ff;
      den_in        = den_ff;
      step_in       = step_ff;
      rd_in         = rd_ff;
      pts_in        = pts_ff;
      t2_in         = t2_ff;
      t3_in         = t3_ff;
      prod_in       = prod_ff;
      acc_in        = acc_ff;
      axis_in       = axis_ff;
      term_in       = term_ff;
      rsp_valid_in  = rsp_valid_ff && rsp_stall;
      rsp_data_in   = rsp_data_ff;
      ram_we        = 1'b0;
      ram_waddr     = count_ff[cmr_pkg::IdxW-1:0];
      ram_wdata     = {req_data.point_x, req_data.point_y, req_data.point_z};
      ram_raddr     = '0;

      if (csr_write) begin
         case (csr_paddr[3:2])
            cmr_pkg::RegTotalTime: total_time_in = csr_pwdata[cmr_pkg::TimeW-1:0];
            cmr_pkg::RegLoopMode:  loop_mode_in  = csr_pwdata[0];
            cmr_pkg::RegCycleMode: cycle_mode_in = csr_pwdata[0];
            default: ;
         endcase
      end

      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               status_in = 1'b0;
               phase_in  = '0;
               tick_in   = 1'b0;
               state_in  = ST_FIN;
               case (req_data.opcode)
                  cmr_pkg::OpAppend: begin
                     if (run_ff || count_ff == cmr_pkg::CntW'(cmr_pkg::MaxPoints)) begin
                        status_in = 1'b1;
                     end else begin
                        ram_we   = 1'b1;
                        count_in = count_ff + cmr_pkg::CntW'(1);
                     end
                  end
                  cmr_pkg::OpRemove: begin
                     if (run_ff || count_ff == '0) begin
                        status_in = 1'b1;
                     end else begin
                        count_in = count_ff - cmr_pkg::CntW'(1);
                     end
                  end
                  cmr_pkg::OpClear: begin
                     if (run_ff) begin
                        status_in = 1'b1;
                     end else begin
                        count_in = '0;
                     end
                  end
                  cmr_pkg::OpReset: begin
                     run_in = 1'b0;
                     cur_in = '0;
                     nxt_in = cmr_pkg::IdxW'(1);
                     clk_in = '0;
                     if (count_ff != '0) begin
                        state_in = ST_RSTWB;
                     end
                  end
                  cmr_pkg::OpStart: begin
                     if (run_ff || count_ff < cmr_pkg::CntW'(2)) begin
                        status_in = 1'b1;
                     end else begin
                        rem_in   = '0;
                        quo_in   = total_time_ff;
                        den_in   = cmr_pkg::TimeW'(segs);
                        step_in  = '0;
                        state_in = ST_DIV;
                     end
                  end
                  cmr_pkg::OpTick: begin
                     if (run_ff) begin
                        tick_in  = 1'b1;
                        clk_in   = clk_sum[cmr_pkg::ClkW] ? {cmr_pkg::ClkW{1'b1}}
                                 : clk_sum[cmr_pkg::ClkW-1:0];
                        state_in = ST_ADV;
                     end
                  end
                  default: ;
               endcase
            end
         end
         ST_RSTWB: begin
            pos_in   = cmr_pkg::point_type'(ram_rdata);
            state_in = ST_FIN;
         end
         ST_ADV: begin
            if (clk_ff > {1'b0, len_ff}) begin
               clk_in = clk_ff - {1'b0, len_ff};
               cur_in = nxt_ff;
               if (({1'b0, nxt_ff} + cmr_pkg::CntW'(1)) < count_ff) begin
                  nxt_in = nxt_ff + cmr_pkg::IdxW'(1);
               end else if (cycle_mode_ff) begin
                  nxt_in = '0;
               end else if (loop_mode_ff) begin
                  cur_in = '0;
                  nxt_in = cmr_pkg::IdxW'(1);
               end
            end
            state_in = ST_PH;
         end
         ST_PH: begin
            if (clk_ff >= {1'b0, len_ff}) begin
               phase_in = {1'b1, {(cmr_pkg::PhaseW-1){1'b0}}};
               rd_in    = '0;
               state_in = ST_RD;
            end else begin
               rem_in   = clk_ff[cmr_pkg::TimeW-1:0];
               quo_in   = '0;
               den_in   = len_ff;
               step_in  = '0;
               state_in = ST_DIV;
            end
         end
         ST_DIV: begin
            rem_in  = rem_new;
            quo_in  = quo_new;
            step_in = step_ff + 5'd1;
            if (step_ff == div_last) begin
               if (tick_ff) begin
                  phase_in = {1'b0, quo_new[cmr_pkg::PhaseW-2:0]};
                  rd_in    = '0;
                  state_in = ST_RD;
               end else begin
                  len_in   = (quo_new == '0) ? cmr_pkg::TimeW'(1) : quo_new;
                  run_in   = 1'b1;
                  state_in = ST_FIN;
               end
            end
         end
         ST_RD: begin
            if (rd_ff != 3'd4) begin
               ram_raddr = idx[rd_ff[1:0]];
            end
            if (rd_ff != 3'd0) begin
               pts_in[2'(rd_ff - 3'd1)] = cmr_pkg::point_type'(ram_rdata);
            end
            rd_in = rd_ff + 3'd1;
            if (rd_ff == 3'd4) begin
               state_in = ST_T2;
            end
         end
         ST_T2: begin
            t2_in    = cmr_pkg::PhaseW'((sq + (2*cmr_pkg::PhaseW)'(32768)) >> 16);
            state_in = ST_T3;
         end
         ST_T3: begin
            t3_in    = cmr_pkg::PhaseW'((cu + (2*cmr_pkg::PhaseW)'(32768)) >> 16);
            axis_in  = '0;
            term_in  = '0;
            state_in = ST_MAC;
         end
         ST_MAC: begin
            prod_in = coef_sel * tv_sel;
            if (term_ff == 2'd0) begin
               acc_in = base;
            end else begin
               acc_in = acc_sum;
            end
            term_in = term_ff + 2'd1;
            if (term_ff == 2'd3) begin
               state_in = ST_SAT;
            end
         end
         ST_SAT: begin
            case (axis_ff)
               2'd0: pos_in.x = q_sat;
               2'd1: pos_in.y = q_sat;
               default: pos_in.z = q_sat;
            endcase
            term_in = '0;
            axis_in = axis_ff + 2'd1;
            if (axis_ff == 2'd2) begin
               state_in = ST_FIN;
            end else begin
               state_in = ST_MAC;
            end
         end
         ST_FIN: begin
            if (!rsp_valid_ff || !rsp_stall) begin
               rsp_valid_in              = 1'b1;
               rsp_data_in.pos_x         = pos_ff.x;
               rsp_data_in.pos_y         = pos_ff.y;
               rsp_data_in.pos_z         = pos_ff.z;
               rsp_data_in.segment_index = cur_ff;
               rsp_data_in.phase         = phase_ff;
               rsp_data_in.status        = status_ff;
               rsp_data_in.is_running    = run_ff;
               state_in                  = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         total_time_ff <= cmr_pkg::TimeW'(1000);
         loop_mode_ff  <= 1'b1;
         cycle_mode_ff <= 1'b0;
         count_ff      <= '0;
         cur_ff        <= '0;
         nxt_ff        <= cmr_pkg::IdxW'(1);
         clk_ff        <= '0;
         len_ff        <= '0;
         run_ff        <= 1'b0;
         pos_ff        <= '0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         total_time_ff <= total_time_in;
         loop_mode_ff  <= loop_mode_in;
         cycle_mode_ff <= cycle_mode_in;
         count_ff      <= count_in;
         cur_ff        <= cur_in;
         nxt_ff        <= nxt_in;
         clk_ff        <= clk_in;
         len_ff        <= len_in;
         run_ff        <= run_in;
         pos_ff        <= pos_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      phase_ff    <= phase_in;
      status_ff   <= status_in;
      tick_ff     <= tick_in;
      rem_ff      <= rem_in;
      quo_ff      <= quo_in;
      den_ff      <= den_in;
      step_ff     <= step_in;
      rd_ff       <= rd_in;
      pts_ff      <= pts_in;
      t2_ff       <= t2_in;
      t3_ff       <= t3_in;
      prod_ff     <= prod_in;
      acc_ff      <= acc_in;
      axis_ff     <= axis_in;
      term_ff     <= term_in;
      rsp_data_ff <= rsp_data_in;
   end

endmodule
